// ----- hdl/mcm_pkg.sv -----
`default_nettype none
package mcm_pkg;

  localparam int DIM_W        = 10;
  localparam int COST_W       = 48;
  localparam int PROD_W       = 3 * DIM_W;
  localparam int MAX_DIMS_DEF = 64;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [3:0] {
    S_LOAD,
    S_IV_A,
    S_IV_B,
    S_K_RD,
    S_K_MUL1,
    S_K_MUL2,
    S_K_ACC,
    S_WR,
    S_OUT
  } state_t;

  // datapath controls, one step of the sequencer
  typedef struct packed {
    logic dim_we;
    logic cost_we;
    logic lat_dims;
    logic init_best;
    logic clr_best;
    logic mul_first;
    logic mul_second;
    logic acc;
    logic k_is_i;
    logic k1_is_j;
  } dp_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/matrix_chain_min_cost_top.sv -----
// matrix chain minimum cost
// input channel (in_*): one chain dimension per item in in_tdata[9:0]; in_tlast
// marks the final dimension of the chain. dimensions load at one item per cycle.
// up to MAX_DIMS dimensions are kept; further ones are dropped and flagged.
// after the last item the block drops in_tready and runs the interval recurrence
// on one shared multiply/add/compare unit over two block memories (dimensions,
// interval costs). each interval (i,j) first fetches its outer dimensions,
// then for each of its j-i split points reads, multiplies twice through the
// one multiplier, accumulates and compares, and finally writes the table.
// chains under three dims skip the recurrence.
// result channel (out_*): one item per chain, min_cost in out_tdata[47:0],
// out_tuser set when the cost saturated at 2^48-1 or dimensions were dropped.
// the result is held in registers until out_tready; in_tready stays low
// until it is taken, then the next chain can load.
// reset (rst_n low, synchronous) empties the dimension count and flag; the
// memories need no clearing since every entry is written before it is read.
`default_nettype none
module matrix_chain_min_cost_top #(
  parameter int MAX_DIMS = mcm_pkg::MAX_DIMS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [9:0] dimension, [15:10] zero
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // [47:0] min_cost
  output logic        out_tuser   // saturated or dimensions dropped
);

  localparam int IW = $clog2(MAX_DIMS);

  mcm_pkg::dp_ctl_t            ctl;
  logic [IW-1:0]               dim_waddr, dim_raddr_a, dim_raddr_b;
  logic [2*IW-1:0]             cost_waddr, cost_raddr_a, cost_raddr_b;
  logic                        ovf;
  logic [mcm_pkg::COST_W-1:0]  best;

  mcm_ctrl #(
    .MAX_DIMS (MAX_DIMS),
    .IW       (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tlast     (in_tlast),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .ctl          (ctl),
    .dim_waddr    (dim_waddr),
    .dim_raddr_a  (dim_raddr_a),
    .dim_raddr_b  (dim_raddr_b),
    .cost_waddr   (cost_waddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b),
    .ovf          (ovf)
  );

  mcm_datapath #(
    .MAX_DIMS (MAX_DIMS),
    .IW       (IW)
  ) u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .wr_dimension (in_tdata[mcm_pkg::DIM_W-1:0]),
    .dim_waddr    (dim_waddr),
    .dim_raddr_a  (dim_raddr_a),
    .dim_raddr_b  (dim_raddr_b),
    .cost_waddr   (cost_waddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b),
    .best         (best)
  );

  assign out_tdata = best;
  assign out_tuser = ovf || (best == mcm_pkg::COST_MAX);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still ready after the last dimension");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("block not ready after result taken");

endmodule
`default_nettype wire

// ----- hdl/mcm_datapath.sv -----
`default_nettype none
module mcm_datapath #(
  parameter int MAX_DIMS = mcm_pkg::MAX_DIMS_DEF,
  parameter int IW       = $clog2(MAX_DIMS)
) (
  input  wire                          clk,
  input  mcm_pkg::dp_ctl_t             ctl,
  input  wire  [mcm_pkg::DIM_W-1:0]    wr_dimension,
  input  wire  [IW-1:0]                dim_waddr,
  input  wire  [IW-1:0]                dim_raddr_a,
  input  wire  [IW-1:0]                dim_raddr_b,
  input  wire  [2*IW-1:0]              cost_waddr,
  input  wire  [2*IW-1:0]              cost_raddr_a,
  input  wire  [2*IW-1:0]              cost_raddr_b,
  output logic [mcm_pkg::COST_W-1:0]   best
);

  localparam int DW = mcm_pkg::DIM_W;
  localparam int CW = mcm_pkg::COST_W;
  localparam int PW = mcm_pkg::PROD_W;

  logic [DW-1:0] dim_mem  [MAX_DIMS];
  logic [CW-1:0] cost_mem [2**(2*IW)];

  logic [DW-1:0]   dra_r, drb_r;
  logic [CW-1:0]   ca_r, cb_r;
  logic [DW-1:0]   pim1_r, pj_r;
  logic [PW-1:0]   prod_r;
  logic [CW:0]     sum_r;
  logic [CW-1:0]   best_r;

  logic [2*DW-1:0] mul_a;
  logic [DW-1:0]   mul_b;
  logic [PW-1:0]   mul_out;
  logic [CW:0]     sum_nxt;
  logic [CW+1:0]   cand_full;
  logic [CW-1:0]   cand;

  always_ff @(posedge clk) begin
    if (ctl.dim_we) begin
      dim_mem[dim_waddr] <= wr_dimension;
    end
    dra_r <= dim_mem[dim_raddr_a];
    drb_r <= dim_mem[dim_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (ctl.cost_we) begin
      cost_mem[cost_waddr] <= best_r;
    end
    ca_r <= cost_mem[cost_raddr_a];
    cb_r <= cost_mem[cost_raddr_b];
  end

  // one multiplier, used twice per split point
  always_comb begin
    mul_a = ctl.mul_second ? prod_r[2*DW-1:0] : {{DW{1'b0}}, pim1_r};
    mul_b = ctl.mul_second ? pj_r : dra_r;
    mul_out = PW'(mul_a * mul_b);
  end

  // diagonal entries are zero and never stored
  always_comb begin
    sum_nxt = (ctl.k_is_i ? (CW+1)'(0) : {1'b0, ca_r}) +
              (ctl.k1_is_j ? (CW+1)'(0) : {1'b0, cb_r});
    cand_full = {1'b0, sum_r} + (CW+2)'(prod_r);
    cand = (cand_full > (CW+2)'(mcm_pkg::COST_MAX)) ? mcm_pkg::COST_MAX : cand_full[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.lat_dims) begin
      pim1_r <= dra_r;
      pj_r   <= drb_r;
    end
    if (ctl.mul_first || ctl.mul_second) begin
      prod_r <= mul_out;
    end
    if (ctl.mul_first) begin
      sum_r <= sum_nxt;
    end
    if (ctl.clr_best) begin
      best_r <= '0;
    end else if (ctl.init_best) begin
      best_r <= mcm_pkg::COST_MAX;
    end else if (ctl.acc && (cand < best_r)) begin
      best_r <= cand;
    end
  end

  assign best = best_r;

endmodule
`default_nettype wire

// ----- hdl/mcm_ctrl.sv -----
`default_nettype none
module mcm_ctrl #(
  parameter int MAX_DIMS = mcm_pkg::MAX_DIMS_DEF,
  parameter int IW       = $clog2(MAX_DIMS),
  parameter int CNT_W    = $clog2(MAX_DIMS + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  input  wire                 in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output mcm_pkg::dp_ctl_t    ctl,
  output logic [IW-1:0]       dim_waddr,
  output logic [IW-1:0]       dim_raddr_a,
  output logic [IW-1:0]       dim_raddr_b,
  output logic [2*IW-1:0]     cost_waddr,
  output logic [2*IW-1:0]     cost_raddr_a,
  output logic [2*IW-1:0]     cost_raddr_b,
  output logic                ovf
);

  mcm_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [IW-1:0]    j_r, j_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic [IW-1:0]    g_r, g_nxt;

  logic             in_acc;
  logic             has_room;
  logic [CNT_W-1:0] count_new;
  logic             short_chain;
  logic [IW-1:0]    last_idx;
  logic             k_is_i, k1_is_j;
  logic             row_end, final_iv;

  always_comb begin
    in_acc      = (state_r == mcm_pkg::S_LOAD) && in_tvalid;
    has_room    = count_r < CNT_W'(MAX_DIMS);
    count_new   = has_room ? count_r + CNT_W'(1) : count_r;
    short_chain = count_new < CNT_W'(3);
    last_idx    = IW'(count_r - CNT_W'(1));
    k_is_i      = (k_r == i_r);
    k1_is_j     = ((k_r + IW'(1)) == j_r);
    row_end     = (j_r == last_idx);
    final_iv    = row_end && (i_r == IW'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcm_pkg::S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = short_chain ? mcm_pkg::S_OUT : mcm_pkg::S_IV_A;
        end
      end
      mcm_pkg::S_IV_A:   state_nxt = mcm_pkg::S_IV_B;
      mcm_pkg::S_IV_B:   state_nxt = mcm_pkg::S_K_RD;
      mcm_pkg::S_K_RD:   state_nxt = mcm_pkg::S_K_MUL1;
      mcm_pkg::S_K_MUL1: state_nxt = mcm_pkg::S_K_MUL2;
      mcm_pkg::S_K_MUL2: state_nxt = mcm_pkg::S_K_ACC;
      mcm_pkg::S_K_ACC:  state_nxt = k1_is_j ? mcm_pkg::S_WR : mcm_pkg::S_K_RD;
      mcm_pkg::S_WR:     state_nxt = final_iv ? mcm_pkg::S_OUT : mcm_pkg::S_IV_A;
      mcm_pkg::S_OUT: begin
        if (out_tready) begin
          state_nxt = mcm_pkg::S_LOAD;
        end
      end
      default:           state_nxt = mcm_pkg::S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    ctl        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ctl.k_is_i  = k_is_i;
    ctl.k1_is_j = k1_is_j;
    case (state_r)
      mcm_pkg::S_LOAD: begin
        in_tready    = 1'b1;
        ctl.dim_we   = in_acc && has_room;
        ctl.clr_best = in_acc && in_tlast && short_chain;
      end
      mcm_pkg::S_IV_A:   ctl.init_best  = 1'b1;
      mcm_pkg::S_IV_B:   ctl.lat_dims   = 1'b1;
      mcm_pkg::S_K_RD:   ctl.acc        = 1'b0;
      mcm_pkg::S_K_MUL1: ctl.mul_first  = 1'b1;
      mcm_pkg::S_K_MUL2: ctl.mul_second = 1'b1;
      mcm_pkg::S_K_ACC:  ctl.acc        = 1'b1;
      mcm_pkg::S_WR:     ctl.cost_we    = 1'b1;
      mcm_pkg::S_OUT:    out_tvalid     = 1'b1;
      default:           ctl.acc        = 1'b0;
    endcase
  end

  always_comb begin
    dim_waddr    = IW'(count_r);
    dim_raddr_a  = (state_r == mcm_pkg::S_IV_A) ? i_r - IW'(1) : k_r;
    dim_raddr_b  = j_r;
    cost_waddr   = {i_r, j_r};
    cost_raddr_a = {i_r, k_r};
    cost_raddr_b = {k_r + IW'(1), j_r};
  end

  // dimension count, overflow flag, interval and split-point indices
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    case (state_r)
      mcm_pkg::S_LOAD: begin
        if (in_acc) begin
          count_nxt = count_new;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          i_nxt = IW'(1);
          g_nxt = IW'(1);
          j_nxt = IW'(2);
        end
      end
      mcm_pkg::S_IV_A: k_nxt = i_r;
      mcm_pkg::S_K_ACC: begin
        if (!k1_is_j) begin
          k_nxt = k_r + IW'(1);
        end
      end
      mcm_pkg::S_WR: begin
        if (row_end) begin
          g_nxt = g_r + IW'(1);
          i_nxt = IW'(1);
          j_nxt = g_r + IW'(2);
        end else begin
          i_nxt = i_r + IW'(1);
          j_nxt = j_r + IW'(1);
        end
      end
      mcm_pkg::S_OUT: begin
        if (out_tready) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: k_nxt = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcm_pkg::S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign ovf = ovf_r;

endmodule
`default_nettype wire
